// ===== src/rhpm_pkg.sv =====
`default_nettype none
package rhpm_pkg;
   localparam int PatternMax = 32;
   localparam int PtrBits = $clog2(PatternMax);
   localparam int LenBits = 6;
   localparam int OffsetBits = 32;
   localparam int HashBits = 30;
   localparam int CfgBits = 64;
   localparam int CfgIdxBits = 3;
   localparam logic [HashBits-1:0] HashMod = 30'd1000000009;
   localparam logic [4:0] HashBase = 5'd31;
   localparam logic [7:0] SymBias = 8'd96;

   localparam logic [CfgIdxBits-1:0] RegLength = 3'd0;
   localparam logic [CfgIdxBits-1:0] RegBytes0 = 3'd1;
   localparam logic [CfgIdxBits-1:0] RegBytes3 = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_SUB, ST_SUBRED, ST_MUL, ST_ADD, ST_CHK, ST_CMP,
      ST_OUT, ST_PAT, ST_PATRED
   } state_type;

   // symbol value of a byte, already in 0..mod-1
   function automatic logic [HashBits-1:0] sym_of(input logic [7:0] b);
      logic [HashBits-1:0] r;
      if (b >= SymBias) r = HashBits'(b - SymBias);
      else r = HashMod - HashBits'(SymBias - b);
      return r;
   endfunction

   // x * 31 reduced; x < mod, product < 31*mod so five conditional subtracts
   function automatic logic [HashBits-1:0] mul31_mod(input logic [HashBits-1:0] x);
      logic [HashBits+4:0] r;
      r = (HashBits+5)'(x) * (HashBits+5)'(HashBase);
      for (int k = 4; k >= 0; k--)
         if (r >= ((HashBits+5)'(HashMod) << k)) r = r - ((HashBits+5)'(HashMod) << k);
      return HashBits'(r);
   endfunction
endpackage
`default_nettype wire

// ===== src/rhpm_window_ram.sv =====
`default_nettype none
module rhpm_window_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [rhpm_pkg::PtrBits-1:0] wr_addr,
   input  wire logic [7:0]                 wr_data,
   input  wire logic [rhpm_pkg::PtrBits-1:0] rd_addr,
   output logic      [7:0]                 rd_data
);
   logic [7:0] mem [rhpm_pkg::PatternMax];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/rolling_hash_pattern_matcher.sv =====
`default_nettype none
// rolling_hash_pattern_matcher: streaming rabin-karp matcher
// req channel carries text_byte and first_byte; a transfer happens when
// req_valid is high and req_stall low. rsp channel gives match_position and
// position_saturated only for a confirmed match
// csr port: csr_write with csr_index 0 length, 1..4 pattern bytes; a write
// rebuilds the pattern hash with req_stall high
// the window sits in a 32 entry ram used as a circular buffer; each byte is
// one read of the oldest entry, a modular subtract, multiply by 31 and add
// it takes no new byte until it is through with the last; once the window is
// full the old symbol is multiplied by the leading power, 3 bits a cycle;
// a hash hit then compares the window with the pattern byte by byte,
// stopping at the first mismatch, and hands a match to the result register
// reset (synchronous) clears length, pattern, window fill, offset and result;
// ram contents are never read before being written inside the current window
// while rsp_stall is high the result holds; a second match waits inside and
// keeps req_stall high until the result register frees
module rolling_hash_pattern_matcher (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [7:0]   req_text_byte,
   input  wire logic         req_first_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [31:0]       rsp_match_position,
   output logic              rsp_position_saturated,
   input  wire logic         csr_write,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data
);
   localparam int HB = rhpm_pkg::HashBits;
   localparam int PB = rhpm_pkg::PtrBits;
   localparam int DigitSteps = HB / 3;
   localparam logic [rhpm_pkg::OffsetBits-1:0] OffMax = '1;

   rhpm_pkg::state_type state_ff, state_in;
   logic [rhpm_pkg::LenBits-1:0] len_ff, len_in;
   logic [63:0] pat_ff [4];
   logic [HB-1:0] whash_ff, whash_in, phash_ff, phash_in, lpow_ff, lpow_in;
   logic [HB-1:0] tmp_ff, tmp_in;
   logic [HB-1:0] prod_ff, prod_in;
   logic [HB-1:0] shift_ff, shift_in;
   logic [rhpm_pkg::OffsetBits-1:0] off_ff, off_in, cur_ff, cur_in;
   logic [rhpm_pkg::LenBits-1:0] fill_ff, fill_in, cnt_ff, cnt_in;
   logic [PB-1:0] head_ff, head_in;
   logic [7:0] byte_ff, byte_in;
   logic full_ff, full_in;
   logic pat_busy_ff, pat_busy_in;
   logic out_valid_ff, out_valid_in;
   logic [31:0] pos_ff, pos_in;
   logic sat_ff, sat_in;
   logic [rhpm_pkg::LenBits-1:0] m;
   logic [7:0] rd_data;
   logic [PB-1:0] rd_addr;
   logic wr_en;
   logic [HB-1:0] sub_acc;
   logic [HB:0] sum;

   assign m = (len_ff > rhpm_pkg::LenBits'(rhpm_pkg::PatternMax))
              ? rhpm_pkg::LenBits'(rhpm_pkg::PatternMax) : len_ff;

   function automatic logic [7:0] pat_byte(input logic [63:0] p [4],
                                           input logic [rhpm_pkg::LenBits-1:0] i);
      logic [63:0] w;
      w = p[i[4:3]];
      return w[8*i[2:0] +: 8];
   endfunction

   rhpm_window_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(head_ff), .wr_data(byte_ff),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // one horner step of old*lpow: acc*8 + t*digit stays below 15*mod,
   // so four conditional subtracts reduce it
   function automatic logic [HB-1:0] mac_mod(input logic [HB-1:0] acc,
                                             input logic [HB-1:0] t,
                                             input logic [2:0] dig);
      logic [HB+3:0] r;
      r = (HB+4)'({acc, 3'b000}) + (HB+4)'(t) * (HB+4)'(dig);
      for (int k = 3; k >= 0; k--)
         if (r >= ((HB+4)'(rhpm_pkg::HashMod) << k)) r = r - ((HB+4)'(rhpm_pkg::HashMod) << k);
      return HB'(r);
   endfunction

   always_comb begin
      state_in = state_ff; len_in = len_ff; whash_in = whash_ff; phash_in = phash_ff;
      lpow_in = lpow_ff; tmp_in = tmp_ff; prod_in = prod_ff; off_in = off_ff;
      cur_in = cur_ff; fill_in = fill_ff; cnt_in = cnt_ff; head_in = head_ff;
      byte_in = byte_ff; full_in = full_ff; pat_busy_in = pat_busy_ff;
      shift_in = shift_ff;
      pos_in = pos_ff; sat_in = sat_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      wr_en = 1'b0;
      rd_addr = head_ff - PB'(m);
      sub_acc = '0; sum = '0;
      req_stall = (state_ff != rhpm_pkg::ST_IDLE) || pat_busy_ff;
      case (state_ff)
         rhpm_pkg::ST_IDLE: begin
            if (pat_busy_ff) begin
               state_in = rhpm_pkg::ST_PAT; cnt_in = '0;
               phash_in = '0; lpow_in = HB'(1); pat_busy_in = 1'b0;
            end else if (req_valid) begin
               byte_in = req_text_byte;
               if (req_first_byte) begin
                  fill_in = '0; whash_in = '0; cur_in = '0;
                  off_in = (OffMax != '0) ? rhpm_pkg::OffsetBits'(1) : '0;
               end else begin
                  cur_in = off_ff;
                  if (off_ff != OffMax) off_in = off_ff + 1'b1;
               end
               state_in = rhpm_pkg::ST_RD;
            end
         end
         rhpm_pkg::ST_RD: begin
            // ram read of the oldest byte issued this cycle via rd_addr
            full_in = (m != '0) && (fill_ff >= m);
            if (m == '0) begin
               wr_en = 1'b1; head_in = head_ff + 1'b1; state_in = rhpm_pkg::ST_IDLE;
            end else begin
               if (fill_ff < m) fill_in = fill_ff + 1'b1;
               state_in = rhpm_pkg::ST_SUB;
            end
         end
         rhpm_pkg::ST_SUB: begin
            tmp_in = rhpm_pkg::sym_of(rd_data);
            prod_in = '0;
            shift_in = lpow_ff;
            cnt_in = '0;
            state_in = full_ff ? rhpm_pkg::ST_SUBRED : rhpm_pkg::ST_MUL;
         end
         rhpm_pkg::ST_SUBRED: begin
            // old*lpow mod, lpow digits msb first, three bits a cycle
            sub_acc = mac_mod(prod_ff, tmp_ff, shift_ff[HB-1 -: 3]);
            prod_in = sub_acc;
            shift_in = shift_ff << 3;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rhpm_pkg::LenBits'(DigitSteps - 1)) begin
               sum = {1'b0, whash_ff} + (HB+1)'(rhpm_pkg::HashMod) - {1'b0, sub_acc};
               whash_in = (sum >= (HB+1)'(rhpm_pkg::HashMod))
                          ? HB'(sum - (HB+1)'(rhpm_pkg::HashMod)) : HB'(sum);
               state_in = rhpm_pkg::ST_MUL;
            end
         end
         rhpm_pkg::ST_MUL: begin
            whash_in = rhpm_pkg::mul31_mod(whash_ff);
            state_in = rhpm_pkg::ST_ADD;
         end
         rhpm_pkg::ST_ADD: begin
            sum = {1'b0, whash_ff} + {1'b0, rhpm_pkg::sym_of(byte_ff)};
            whash_in = (sum >= (HB+1)'(rhpm_pkg::HashMod)) ? HB'(sum - (HB+1)'(rhpm_pkg::HashMod)) : HB'(sum);
            wr_en = 1'b1; head_in = head_ff + 1'b1;
            cnt_in = '0;
            state_in = rhpm_pkg::ST_CHK;
         end
         rhpm_pkg::ST_CHK: begin
            rd_addr = head_ff - PB'(m) + PB'(cnt_ff);
            if (fill_ff == m && whash_ff == phash_ff) state_in = rhpm_pkg::ST_CMP;
            else state_in = rhpm_pkg::ST_IDLE;
            cnt_in = '0;
         end
         rhpm_pkg::ST_CMP: begin
            rd_addr = head_ff - PB'(m) + PB'(cnt_ff + 1'b1);
            if (rd_data != pat_byte(pat_ff, cnt_ff)) state_in = rhpm_pkg::ST_IDLE;
            else if (cnt_ff + 1'b1 == m) state_in = rhpm_pkg::ST_OUT;
            cnt_in = cnt_ff + 1'b1;
         end
         rhpm_pkg::ST_OUT: begin
            // wait for the result register to free up
            if (!out_valid_ff || !rsp_stall) begin
               pos_in = 32'((cur_ff >= rhpm_pkg::OffsetBits'(m - 1'b1))
                             ? cur_ff - rhpm_pkg::OffsetBits'(m - 1'b1) : '0);
               sat_in = (off_ff == OffMax);
               out_valid_in = 1'b1;
               state_in = rhpm_pkg::ST_IDLE;
            end
         end
         rhpm_pkg::ST_PAT: begin
            if (cnt_ff >= m) state_in = rhpm_pkg::ST_IDLE;
            else begin
               phash_in = rhpm_pkg::mul31_mod(phash_ff);
               if (cnt_ff + 1'b1 < m) lpow_in = rhpm_pkg::mul31_mod(lpow_ff);
               state_in = rhpm_pkg::ST_PATRED;
            end
         end
         rhpm_pkg::ST_PATRED: begin
            sum = {1'b0, phash_ff} + {1'b0, rhpm_pkg::sym_of(pat_byte(pat_ff, cnt_ff))};
            phash_in = (sum >= (HB+1)'(rhpm_pkg::HashMod)) ? HB'(sum - (HB+1)'(rhpm_pkg::HashMod)) : HB'(sum);
            cnt_in = cnt_ff + 1'b1;
            state_in = rhpm_pkg::ST_PAT;
         end
         default: state_in = rhpm_pkg::ST_IDLE;
      endcase
      if (csr_write) begin
         if (csr_index == rhpm_pkg::RegLength) begin
            len_in = csr_data[rhpm_pkg::LenBits-1:0];
            fill_in = '0; whash_in = '0; pat_busy_in = 1'b1;
         end else if (csr_index <= rhpm_pkg::RegBytes3) begin
            pat_busy_in = 1'b1;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_match_position = pos_ff;
   assign rsp_position_saturated = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhpm_pkg::ST_IDLE; len_ff <= '0; whash_ff <= '0; phash_ff <= '0;
         lpow_ff <= HB'(1); off_ff <= '0; fill_ff <= '0; head_ff <= '0;
         pat_busy_ff <= 1'b0; out_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) pat_ff[k] <= '0;
      end else begin
         state_ff <= state_in; len_ff <= len_in; whash_ff <= whash_in; phash_ff <= phash_in;
         lpow_ff <= lpow_in; off_ff <= off_in; fill_ff <= fill_in; head_ff <= head_in;
         pat_busy_ff <= pat_busy_in; out_valid_ff <= out_valid_in;
         if (csr_write && csr_index >= rhpm_pkg::RegBytes0 && csr_index <= rhpm_pkg::RegBytes3)
            pat_ff[2'(csr_index - rhpm_pkg::RegBytes0)] <= csr_data;
      end
      tmp_ff <= tmp_in; prod_ff <= prod_in; shift_ff <= shift_in; cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      byte_ff <= byte_in; full_ff <= full_in; pos_ff <= pos_in; sat_ff <= sat_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match_position)
                                 && $stable(rsp_position_saturated))
      else $error("result dropped under stall");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != rhpm_pkg::ST_IDLE |-> req_stall) else $error("item taken while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= rhpm_pkg::LenBits'(rhpm_pkg::PatternMax)) else $error("fill overflow");
endmodule
`default_nettype wire

// ===== verif/match_checker.sv =====
`default_nettype none
module match_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_first_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_match_position,
   input  wire logic        rsp_position_saturated,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   output int               pending,
   output int               failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned Modulus = 64'd1000000009;
   localparam longint unsigned OffsetMax = (64'd1 << rhpm_pkg::OffsetBits) - 1;

   typedef struct packed {
      logic [31:0] position;
      logic        saturated;
   } match_type;

   match_type matches_due[$];

   logic [rhpm_pkg::LenBits-1:0] length_reg;
   logic [63:0]        pattern_reg [4];
   logic [7:0]         window [rhpm_pkg::PatternMax];
   longint unsigned    win_hash, pat_hash, lead_pow, offset, fill;

   function automatic longint unsigned symbol(input logic [7:0] b);
      return (longint'(b) + Modulus - 96) % Modulus;
   endfunction

   function automatic longint unsigned active_len();
      return (length_reg > rhpm_pkg::PatternMax) ? rhpm_pkg::PatternMax : length_reg;
   endfunction

   function automatic logic [7:0] pattern_byte(input longint unsigned i);
      return (i >= 32) ? 8'h00 : pattern_reg[i >> 3][8 * (i & 7) +: 8];
   endfunction

   task automatic rehash_pattern();
      longint unsigned m;
      m = active_len();
      pat_hash = 0;
      lead_pow = 1;
      for (longint unsigned i = 0; i < m; i++) begin
         pat_hash = (pat_hash * 31 + symbol(pattern_byte(i))) % Modulus;
         if (i + 1 < m) lead_pow = (lead_pow * 31) % Modulus;
      end
   endtask

   task automatic empty_window();
      foreach (window[i]) window[i] = 8'h00;
      win_hash = 0;
      fill = 0;
   endtask

   task automatic take_byte(input logic [7:0] b, input logic first);
      longint unsigned m, here, drop;
      bit hit;
      match_type found;
      m = active_len();
      if (first) begin
         empty_window();
         offset = 0;
      end
      here = offset;
      if (offset < OffsetMax) offset++;
      if (m != 0) begin
         if (fill < m) fill++;
         else begin
            drop = (symbol(window[rhpm_pkg::PatternMax - m]) * lead_pow) % Modulus;
            win_hash = (win_hash + Modulus - drop) % Modulus;
         end
         win_hash = (win_hash * 31 + symbol(b)) % Modulus;
      end
      for (int i = 0; i < rhpm_pkg::PatternMax - 1; i++) window[i] = window[i + 1];
      window[rhpm_pkg::PatternMax - 1] = b;
      hit = (m != 0) && (fill == m) && (win_hash == pat_hash);
      // hash agreement is only a candidate; confirm byte by byte
      for (longint unsigned i = 0; hit && i < m; i++)
         if (window[rhpm_pkg::PatternMax - m + i] != pattern_byte(i)) hit = 0;
      if (hit) begin
         found.position = 32'((here >= m - 1) ? here - (m - 1) : 0);
         found.saturated = (offset == OffsetMax);
         matches_due = {matches_due, found};
      end
   endtask

   always @(posedge clock) begin
      match_type want;
      if (reset) begin
         length_reg = '0;
         foreach (pattern_reg[i]) pattern_reg[i] = '0;
         empty_window();
         offset = 0;
         rehash_pattern();
         matches_due.delete();
         failures = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == rhpm_pkg::RegLength) begin
               length_reg = csr_data[rhpm_pkg::LenBits-1:0];
               empty_window();
               rehash_pattern();
            end else if (csr_index >= rhpm_pkg::RegBytes0 &&
                         csr_index <= rhpm_pkg::RegBytes3) begin
               pattern_reg[csr_index - rhpm_pkg::RegBytes0] = csr_data;
               rehash_pattern();
            end
         end
         if (req_valid && !req_stall) take_byte(req_text_byte, req_first_byte);
         if (rsp_valid && !rsp_stall) begin
            if (matches_due.size() == 0) begin
               $error("unexpected match at position %0d", rsp_match_position);
               failures++;
            end else begin
               want = matches_due.pop_front();
               if (rsp_match_position !== want.position) begin
                  $error("match_position: expected %0d, got %0d",
                         want.position, rsp_match_position);
                  failures++;
               end
               if (rsp_position_saturated !== want.saturated) begin
                  $error("position_saturated: expected %0b, got %0b",
                         want.saturated, rsp_position_saturated);
                  failures++;
               end
            end
         end
      end
      pending = matches_due.size();
   end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1000000;
   localparam int SettleCycles = 100;   // covers one item plus a full-length compare
   localparam int RehashCycles = 80;    // covers a pattern hash rebuild at full length

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_text_byte = '0;
   logic        req_first_byte = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_match_position;
   logic        rsp_position_saturated;
   logic        csr_write = 0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   int  pending, failures;
   int  cycle_count = 0;
   bit  eager_send = 0;     // no sender gaps in this stretch
   bit  eager_take = 0;     // no receiver stalls in this stretch
   bit  choke = 0;          // ask the receiver for one long hold-off
   int  pat_len;            // effective pattern length currently programmed
   logic [7:0] pat [32];    // pattern bytes currently programmed
   logic [7:0] alphabet [3];

   rolling_hash_pattern_matcher dut (.*);

   match_checker u_checker (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: draws a stall per result, and one long hold-off when choke is set
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         if (choke) begin
            hold = 600;
            choke = 0;
         end else hold = eager_take ? 0 : $urandom_range(0, 17);
         if (hold > 0) begin
            rsp_stall <= 1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // one byte transfer; valid stays high afterwards so back-to-back works
   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      gap = eager_send ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_text_byte <= b;
      req_first_byte <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and let every outstanding match drain
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      repeat (RehashCycles) @(posedge clock);
   endtask

   // program pattern bytes from pat[], and the length too if asked
   task automatic program_pattern(input logic [5:0] len, input bit set_len);
      logic [63:0] word;
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 8; k++) word[8*k +: 8] = pat[8*r + k];
         write_reg(rhpm_pkg::RegBytes0 + 3'(r), word);
      end
      if (set_len) begin
         write_reg(rhpm_pkg::RegLength, 64'(len));
         pat_len = (len > rhpm_pkg::PatternMax) ? rhpm_pkg::PatternMax : len;
      end
   endtask

   task automatic send_text(input logic [7:0] s [], input logic first);
      foreach (s[i]) send_byte(s[i], first && i == 0);
   endtask

   initial begin
      int sent;
      logic [5:0] len;
      logic [5:0] len_choices [10] = '{1, 2, 3, 4, 5, 8, 32, 63, 0, 0};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      pat_len = 0;
      foreach (pat[i]) pat[i] = 8'h00;

      // length zero after reset: bytes advance the offset but never match
      send_text('{8'h00, 8'hff, 8'h61}, 1);
      drain();

      // short pattern "aba": overlapping matches and a restart mid-pattern
      pat[0] = "a"; pat[1] = "b"; pat[2] = "a";
      program_pattern(3, 1);
      send_text('{"a", "b", "a", "b", "a", "x", "a", "b"}, 0);
      send_text('{"a", "b", "a"}, 1);
      drain();

      // single byte pattern at the top code, text with a byte whose symbol wraps below zero
      pat[0] = 8'hff;
      program_pattern(1, 1);
      send_text('{8'hff, 8'h00, 8'hff}, 0);
      drain();

      // random phases: mostly pattern-shaped text from a tiny alphabet
      sent = 0;
      for (int p = 0; sent < 1400; p++) begin
         foreach (alphabet[i]) alphabet[i] = 8'($urandom);
         foreach (pat[i]) pat[i] = alphabet[$urandom_range(0, 2)];
         len = (p % 10 == 9) ? 6'($urandom_range(0, 63)) : len_choices[p % 10];
         // phases with p % 3 == 1 after the first two keep the window: bytes rewritten only
         program_pattern(len, p < 2 || (p % 3 != 1));
         eager_send = (p % 4 == 1);
         eager_take = (p % 4 == 2);
         if (p == 3) choke = 1;
         for (int n = 0; n < 110; ) begin
            int r;
            logic first;
            r = $urandom_range(0, 9);
            first = ($urandom_range(0, 49) == 0);
            if (r < 4 && pat_len > 0) begin
               for (int i = 0; i < pat_len; i++) send_byte(pat[i], first && i == 0);
               n += pat_len;
            end else begin
               send_byte((r == 9) ? 8'($urandom) : alphabet[$urandom_range(0, 2)], first);
               n++;
            end
         end
         sent += 110;
         drain();
      end

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== rolling_hash_pattern_matcher.f =====
src/rhpm_pkg.sv
src/rhpm_window_ram.sv
src/rolling_hash_pattern_matcher.sv
verif/match_checker.sv
verif/testbench.sv
